### design/rbp_pkg.sv
package rbp_pkg;

	localparam int CODE_W    = 10;
	localparam int COUNT_W   = 8;
	localparam int DELAY_W   = 24;
	localparam int MODE_W    = 2;
	localparam int NCODE_W   = 3;
	localparam int TABLE_W   = 40;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 40;

	// number of compare slots; slots past the table register read as code 0
	localparam int CODE_SLOTS  = 4;
	localparam int TABLE_SLOTS = TABLE_W / CODE_W;
	localparam int EXT_SLOTS   = (CODE_SLOTS > TABLE_SLOTS) ? CODE_SLOTS : TABLE_SLOTS;
	localparam int EXT_W       = EXT_SLOTS * CODE_W;

	// products are formed at this width: base << 23 fits in 47 bits
	localparam int PROD_W = 2 * DELAY_W;

	// linear product: base times count fits in 32 bits
	localparam int LIN_W = DELAY_W + COUNT_W;

	localparam logic [CODE_W-1:0] STATUS_TOO_MANY = 10'd429;
	localparam logic [CODE_W-1:0] STATUS_SRV_LO   = 10'd500;
	localparam logic [CODE_W-1:0] STATUS_SRV_END  = 10'd600;

	// shift counts at or above this saturate the exponential delay
	localparam logic [COUNT_W-1:0] EXP_SAT_COUNT = 8'd24;

	typedef enum logic [MODE_W-1:0] {
		MODE_NONE   = 2'd0,
		MODE_FIXED  = 2'd1,
		MODE_LINEAR = 2'd2,
		MODE_EXP    = 2'd3
	} backoff_mode_t;

	localparam logic [CFG_IDX_W-1:0] REG_MAX_RETRIES   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BACKOFF_MODE  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BASE_DELAY    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DELAY_CEILING = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CODE_COUNT    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_CODE_TABLE    = 3'd5;

	typedef struct packed {
		logic [COUNT_W-1:0] max_retries;
		backoff_mode_t      backoff_mode;
		logic [DELAY_W-1:0] base_delay;
		logic [DELAY_W-1:0] delay_ceiling;
		logic [NCODE_W-1:0] code_count;
		logic [TABLE_W-1:0] code_table;
	} rbp_cfg_t;

endpackage

### design/rbp_cfg_regs.sv
module rbp_cfg_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [rbp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [rbp_pkg::CFG_DAT_W-1:0] cfg_data,
	output rbp_pkg::rbp_cfg_t             cfg
);
	import rbp_pkg::*;

	rbp_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_retries   <= 8'd3;
			cfg_q.backoff_mode  <= MODE_EXP;
			cfg_q.base_delay    <= 24'd1000;
			cfg_q.delay_ceiling <= 24'd30000;
			cfg_q.code_count    <= '0;
			cfg_q.code_table    <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MAX_RETRIES:   cfg_q.max_retries   <= cfg_data[COUNT_W-1:0];
				REG_BACKOFF_MODE:  cfg_q.backoff_mode  <= backoff_mode_t'(cfg_data[MODE_W-1:0]);
				REG_BASE_DELAY:    cfg_q.base_delay    <= cfg_data[DELAY_W-1:0];
				REG_DELAY_CEILING: cfg_q.delay_ceiling <= cfg_data[DELAY_W-1:0];
				REG_CODE_COUNT:    cfg_q.code_count    <= cfg_data[NCODE_W-1:0];
				REG_CODE_TABLE:    cfg_q.code_table    <= cfg_data[TABLE_W-1:0];
				default: begin
					// drop writes to unused indices
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### design/rbp_retry_check.sv
module rbp_retry_check (
	input  rbp_pkg::rbp_cfg_t           cfg,
	input  logic [rbp_pkg::CODE_W-1:0]  status_code,
	input  logic [rbp_pkg::COUNT_W-1:0] attempt_count,
	output logic                        do_retry
);
	import rbp_pkg::*;

	logic [EXT_W-1:0] ext_table;
	logic [3:0]       n_slots;
	logic             hit;
	logic             dflt_hit;

	assign ext_table = EXT_W'(cfg.code_table);
	assign dflt_hit  = (status_code == STATUS_TOO_MANY) ||
	                   ((status_code >= STATUS_SRV_LO) && (status_code < STATUS_SRV_END));

	always_comb begin
		if ({1'b0, cfg.code_count} > 4'(CODE_SLOTS)) begin
			n_slots = 4'(CODE_SLOTS);
		end else begin
			n_slots = {1'b0, cfg.code_count};
		end
		hit = 1'b0;
		for (int i = 0; i < CODE_SLOTS; i++) begin
			if ((n_slots > 4'(i)) && (ext_table[i*CODE_W +: CODE_W] == status_code)) begin
				hit = 1'b1;
			end
		end
	end

	always_comb begin
		if (attempt_count >= cfg.max_retries) begin
			do_retry = 1'b0;
		end else if (cfg.code_count == '0) begin
			do_retry = dflt_hit;
		end else begin
			do_retry = hit;
		end
	end

endmodule

### design/rbp_delay_calc.sv
module rbp_delay_calc (
	input  rbp_pkg::rbp_cfg_t           cfg,
	input  logic [rbp_pkg::COUNT_W-1:0] attempt_count,
	output logic [rbp_pkg::DELAY_W-1:0] wait_ms
);
	import rbp_pkg::*;

	logic [PROD_W-1:0] raw;
	logic              sat;
	logic              clamp_en;

	always_comb begin
		raw      = '0;
		sat      = 1'b0;
		clamp_en = 1'b0;
		case (cfg.backoff_mode)
			MODE_NONE: begin
				raw = '0;
			end
			MODE_FIXED: begin
				raw = PROD_W'(cfg.base_delay);
			end
			MODE_LINEAR: begin
				clamp_en = 1'b1;
				raw      = PROD_W'(LIN_W'(cfg.base_delay) * LIN_W'(attempt_count));
			end
			MODE_EXP: begin
				clamp_en = 1'b1;
				if (cfg.base_delay == '0) begin
					raw = '0;
				end else if (attempt_count >= EXP_SAT_COUNT) begin
					sat = 1'b1;
				end else begin
					raw = PROD_W'(cfg.base_delay) << attempt_count[4:0];
				end
			end
			default: begin
				raw = '0;
			end
		endcase
	end

	always_comb begin
		if (attempt_count == '0) begin
			wait_ms = '0;
		end else if (clamp_en && (sat || (raw > PROD_W'(cfg.delay_ceiling)))) begin
			wait_ms = cfg.delay_ceiling;
		end else begin
			wait_ms = raw[DELAY_W-1:0];
		end
	end

endmodule

### design/retry_backoff_policy.sv
// Retry policy: turns a response status and a retry count into a retry
// decision and a backoff delay in milliseconds.
//
// Command channel: pulse start with status_code and attempt_count; the
// transfer happens at any rising edge where start is high and busy is low.
// busy never rises, so a new command may be given in every cycle.
// Result channel: done is high for exactly one cycle with do_retry and
// wait_ms alongside. The command is captured in the input register at
// its transfer edge; the result register then loads the decision and
// delay and raises done. The result cannot be held
// off; a receiver that misses the cycle loses the result.
// Throughput is one command per cycle; the path between the two registers
// is one 24x8 multiply or one barrel shift, then a compare against the
// ceiling.
// Configuration: cfg_we with cfg_index and cfg_data writes one register in
// the cycle it is seen. Write only while no command is in flight.
// Reset: arst_n clears the pipeline and loads max_retries 3, exponential
// mode, base 1000 ms, ceiling 30000 ms and the default status rule.
module retry_backoff_policy (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [rbp_pkg::CODE_W-1:0]    status_code,
	input  logic [rbp_pkg::COUNT_W-1:0]   attempt_count,
	output logic                          done,
	output logic                          do_retry,
	output logic [rbp_pkg::DELAY_W-1:0]   wait_ms,
	input  logic                          cfg_we,
	input  logic [rbp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [rbp_pkg::CFG_DAT_W-1:0] cfg_data
);
	import rbp_pkg::*;

	rbp_cfg_t           cfg;
	logic               accept;

	// input register
	logic               valid_s1;
	logic [CODE_W-1:0]  status_s1;
	logic [COUNT_W-1:0] count_s1;

	// combinational results between the two registers
	logic               retry_c;
	logic [DELAY_W-1:0] wait_c;

	// result register
	logic               valid_s2;
	logic               do_retry_s2;
	logic [DELAY_W-1:0] wait_ms_s2;

	// The block never stalls: every command is taken as offered.
	assign busy   = 1'b0;
	assign accept = start && !busy;

	rbp_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Control of the two stages: advance the valid flags every cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
		end
	end

	// Payload: capture the command on transfer, hold otherwise.
	always_ff @(posedge clk) begin
		if (accept) begin
			status_s1 <= status_code;
			count_s1  <= attempt_count;
		end
	end

	rbp_retry_check u_retry (
		.cfg           (cfg),
		.status_code   (status_s1),
		.attempt_count (count_s1),
		.do_retry      (retry_c)
	);

	// Delay is worked out regardless of the retry decision.
	rbp_delay_calc u_delay (
		.cfg           (cfg),
		.attempt_count (count_s1),
		.wait_ms       (wait_c)
	);

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			do_retry_s2 <= retry_c;
			wait_ms_s2  <= wait_c;
		end
	end

	assign done     = valid_s2;
	assign do_retry = do_retry_s2;
	assign wait_ms  = wait_ms_s2;

`ifndef SYNTH
	// every accepted command yields a result after the input and result registers
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> ##1 done)
		else $error("result strobe missing after command transfer");

	// no result without a command accepted ahead of the input and result registers
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, 2))
		else $error("result strobe without a command");

	// a count of zero always gives no delay
	a_zero_count_delay: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && (count_s1 == '0)) |=> (wait_ms == '0))
		else $error("non-zero delay for a zero retry count");
`endif

endmodule

### test/retry_backoff_policy_tb.sv
module retry_backoff_policy_tb;

	import rbp_pkg::*;

	// writes to these indexes must leave every register untouched
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

	localparam int PHASES       = 10;
	localparam int PHASE_ITEMS  = 85;
	localparam int SETTLE_EDGES = 4;
	localparam int CYCLE_LIMIT  = 250000;

	typedef struct {
		logic               retry_ok;
		logic [DELAY_W-1:0] delay_ms;
	} backoff_answer_t;

	// Mirrors the policy registers, works out the answer for every accepted
	// request and holds the answers until the block produces them in order.
	class retry_decision_book;
		logic [COUNT_W-1:0] max_retries_q;
		backoff_mode_t      mode_q;
		logic [DELAY_W-1:0] base_q;
		logic [DELAY_W-1:0] ceiling_q;
		logic [NCODE_W-1:0] code_count_q;
		logic [TABLE_W-1:0] code_table_q;
		backoff_answer_t    pending_answers[$];
		int                 mismatches;

		function new();
			max_retries_q = 8'd3;
			mode_q        = MODE_EXP;
			base_q        = 24'd1000;
			ceiling_q     = 24'd30000;
			code_count_q  = '0;
			code_table_q  = '0;
			mismatches    = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
			case (idx)
				REG_MAX_RETRIES:   max_retries_q = val[COUNT_W-1:0];
				REG_BACKOFF_MODE:  mode_q = backoff_mode_t'(val[MODE_W-1:0]);
				REG_BASE_DELAY:    base_q = val[DELAY_W-1:0];
				REG_DELAY_CEILING: ceiling_q = val[DELAY_W-1:0];
				REG_CODE_COUNT:    code_count_q = val[NCODE_W-1:0];
				REG_CODE_TABLE:    code_table_q = val[TABLE_W-1:0];
				default: ;
			endcase
		endfunction

		function logic retry_allowed(logic [CODE_W-1:0] status, logic [COUNT_W-1:0] count);
			int slots;
			if (count >= max_retries_q)
				return 1'b0;
			if (code_count_q == 0)
				return status == STATUS_TOO_MANY ||
					(status >= STATUS_SRV_LO && status < STATUS_SRV_END);
			// a count past the compare slots is taken as all of them;
			// a slot beyond the table register reads as code 0
			slots = (code_count_q > CODE_SLOTS) ? CODE_SLOTS : int'(code_count_q);
			for (int i = 0; i < slots; i++)
				if (((i < TABLE_SLOTS) ? code_table_q[CODE_W*i +: CODE_W] : '0) == status)
					return 1'b1;
			return 1'b0;
		endfunction

		function logic [DELAY_W-1:0] backoff_for(logic [COUNT_W-1:0] count);
			logic [63:0] d;
			if (count == 0)
				return '0;
			case (mode_q)
				MODE_NONE:   return '0;
				MODE_FIXED:  return base_q;
				MODE_LINEAR: d = 64'(base_q) * 64'(count);
				default: begin
					if (base_q == 0)
						d = 0;
					else if (count >= EXP_SAT_COUNT)
						d = 64'(1) << DELAY_W;
					else
						d = 64'(base_q) << count;
				end
			endcase
			// clamp; anything past 24 bits ends at the ceiling as well
			if (d > 64'(ceiling_q))
				d = 64'(ceiling_q);
			return d[DELAY_W-1:0];
		endfunction

		function void note_request(logic [CODE_W-1:0] status, logic [COUNT_W-1:0] count);
			backoff_answer_t a;
			a.retry_ok = retry_allowed(status, count);
			a.delay_ms = backoff_for(count);
			pending_answers.insert(pending_answers.size(), a);
		endfunction

		function void check_answer(logic retry_ok, logic [DELAY_W-1:0] delay_ms);
			backoff_answer_t a;
			if (pending_answers.size() == 0) begin
				$display("%0t: unexpected result, got retry %0b delay %0d", $time,
					retry_ok, delay_ms);
				mismatches++;
				return;
			end
			a = pending_answers[0];
			pending_answers.delete(0);
			if (retry_ok !== a.retry_ok) begin
				$display("%0t: do_retry mismatch, expected %0b got %0b", $time,
					a.retry_ok, retry_ok);
				mismatches++;
			end
			if (delay_ms !== a.delay_ms) begin
				$display("%0t: wait_ms mismatch, expected %0d got %0d", $time,
					a.delay_ms, delay_ms);
				mismatches++;
			end
		endfunction

		function int pending();
			return pending_answers.size();
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 start;
	logic                 busy;
	logic [CODE_W-1:0]    status_code;
	logic [COUNT_W-1:0]   attempt_count;
	logic                 done;
	logic                 do_retry;
	logic [DELAY_W-1:0]   wait_ms;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DAT_W-1:0] cfg_data;

	retry_decision_book book;
	int                 cycles;

	retry_backoff_policy dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.status_code   (status_code),
		.attempt_count (attempt_count),
		.done          (done),
		.do_retry      (do_retry),
		.wait_ms       (wait_ms),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Results cannot be held off, so take every strobe at the edge that ends
	// its cycle; outputs are sampled before the block updates them.
	always @(posedge clk) begin
		if (arst_n && done)
			book.check_answer(do_retry, wait_ms);
	end

	// Guard against a hung handshake or lost results.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("retry_backoff_policy_tb: errors");
			$finish;
		end
	end

	// Fill the bits above a register's width with noise; the block must drop them.
	function automatic logic [CFG_DAT_W-1:0] pad_junk(logic [CFG_DAT_W-1:0] v, int w);
		logic [63:0] junk;
		junk = {$urandom, $urandom};
		if (w >= CFG_DAT_W)
			return v;
		return (junk[CFG_DAT_W-1:0] << w) | v;
	endfunction

	// Hold the write enable across a burst of writes; drop it with cfg_close.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		book.set_reg(idx, val);
	endtask

	task automatic cfg_close();
		cfg_we   <= 1'b0;
		cfg_data <= CFG_DAT_W'({$urandom, $urandom});
		@(posedge clk);
	endtask

	// Offer one request and hold it until the transfer takes place.
	task automatic issue(input logic [CODE_W-1:0] s, input logic [COUNT_W-1:0] c);
		start         <= 1'b1;
		status_code   <= s;
		attempt_count <= c;
		do
			@(posedge clk);
		while (busy);
		book.note_request(s, c);
	endtask

	// Mostly no gap, often a short one, now and then a long one.
	task automatic idle_gap(input bit steady);
		int r;
		int n;
		r = $urandom_range(0, 99);
		n = (steady || r < 60) ? 0 : (r < 92) ? $urandom_range(1, 3) : $urandom_range(8, 40);
		if (n != 0) begin
			start         <= 1'b0;
			status_code   <= CODE_W'($urandom);
			attempt_count <= COUNT_W'($urandom);
			repeat (n) @(posedge clk);
		end
	endtask

	// Lower start and let every outstanding result arrive, then settle.
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (book.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_EDGES) @(posedge clk);
	endtask

	function automatic logic [CODE_W-1:0] pick_table_code();
		case ($urandom_range(0, 4))
			0: return STATUS_TOO_MANY;
			1: return STATUS_SRV_LO + CODE_W'($urandom_range(0, 99));
			2: return ($urandom_range(0, 1) != 0) ? '0 : '1;
			default: return CODE_W'($urandom);
		endcase
	endfunction

	// Bias towards codes that can match the active rule, with boundary codes
	// and the out-of-range band mixed in.
	function automatic logic [CODE_W-1:0] pick_status();
		int r;
		r = $urandom_range(0, 9);
		if (r < 4 && book.code_count_q != 0)
			return book.code_table_q[CODE_W*$urandom_range(0, TABLE_SLOTS-1) +: CODE_W];
		if (r < 6)
			return ($urandom_range(0, 3) == 0) ? STATUS_TOO_MANY :
				STATUS_SRV_LO + CODE_W'($urandom_range(0, 99));
		if (r == 6)
			case ($urandom_range(0, 3))
				0: return STATUS_TOO_MANY - CODE_W'(1);
				1: return STATUS_TOO_MANY + CODE_W'(1);
				2: return STATUS_SRV_LO - CODE_W'(1);
				default: return STATUS_SRV_END;
			endcase
		if (r == 7)
			return CODE_W'($urandom_range(1000, 1023));
		return CODE_W'($urandom);
	endfunction

	// Small counts reach the exponential saturation point; counts near the
	// retry limit probe the cut-off.
	function automatic logic [COUNT_W-1:0] pick_count();
		int r;
		int v;
		r = $urandom_range(0, 9);
		if (r < 4)
			return COUNT_W'($urandom_range(0, 30));
		if (r < 7) begin
			v = int'(book.max_retries_q) + $urandom_range(0, 2) - 1;
			if (v < 0)
				v = 0;
			if (v > 255)
				v = 255;
			return COUNT_W'(v);
		end
		return COUNT_W'($urandom);
	endfunction

	// Extremes first, random settings after; every register in every phase.
	task automatic load_settings(input int p);
		logic [COUNT_W-1:0] mr;
		backoff_mode_t      md;
		logic [DELAY_W-1:0] bd;
		logic [DELAY_W-1:0] cl;
		logic [NCODE_W-1:0] nc;
		logic [TABLE_W-1:0] tbl;
		for (int i = 0; i < TABLE_SLOTS; i++)
			tbl[CODE_W*i +: CODE_W] = pick_table_code();
		mr = ($urandom_range(0, 3) == 0) ? COUNT_W'($urandom) : COUNT_W'($urandom_range(0, 40));
		md = backoff_mode_t'($urandom_range(0, 3));
		bd = ($urandom_range(0, 2) == 0) ? DELAY_W'($urandom) : DELAY_W'($urandom_range(0, 5000));
		cl = ($urandom_range(0, 2) == 0) ? DELAY_W'($urandom) : DELAY_W'($urandom_range(0, 90000));
		nc = NCODE_W'($urandom_range(0, 7));
		case (p)
			0: begin
				mr = '1; md = MODE_LINEAR; bd = '1; cl = '1; nc = 3'd0;
			end
			1: begin
				mr = '0; md = MODE_FIXED; bd = '1; cl = '0; nc = 3'd4;
			end
			2: begin
				mr = 8'd200; md = MODE_EXP; bd = 24'd1; cl = '1; nc = 3'd7;
			end
			3: begin
				md = MODE_NONE; nc = 3'd1;
			end
			4: begin
				mr = '1; md = MODE_EXP; bd = '0; cl = '0; nc = NCODE_W'($urandom_range(2, 3));
			end
			default: ;
		endcase
		// unused indexes go first so a stray write would corrupt what follows
		if (p % 2 == 0) begin
			write_reg(REG_SPARE_LO, CFG_DAT_W'({$urandom, $urandom}));
			write_reg(REG_SPARE_HI, CFG_DAT_W'({$urandom, $urandom}));
		end
		write_reg(REG_MAX_RETRIES, pad_junk(CFG_DAT_W'(mr), COUNT_W));
		write_reg(REG_BACKOFF_MODE, pad_junk(CFG_DAT_W'(md), MODE_W));
		write_reg(REG_BASE_DELAY, pad_junk(CFG_DAT_W'(bd), DELAY_W));
		write_reg(REG_DELAY_CEILING, pad_junk(CFG_DAT_W'(cl), DELAY_W));
		write_reg(REG_CODE_COUNT, pad_junk(CFG_DAT_W'(nc), NCODE_W));
		write_reg(REG_CODE_TABLE, CFG_DAT_W'(tbl));
		cfg_close();
	endtask

	initial begin
		bit steady;
		book          = new();
		cycles        = 0;
		arst_n        = 1'b0;
		start         = 1'b0;
		status_code   = '0;
		attempt_count = '0;
		cfg_we        = 1'b0;
		cfg_index     = '0;
		cfg_data      = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed pass on the reset settings: default status rule,
		// exponential backoff, limit of three retries.
		issue(STATUS_TOO_MANY, 8'd0);                 idle_gap(1'b0);
		issue(STATUS_TOO_MANY, 8'd2);                 idle_gap(1'b0);
		issue(STATUS_TOO_MANY, 8'd3);                 idle_gap(1'b0);
		issue(STATUS_SRV_LO, 8'd1);                   idle_gap(1'b0);
		issue(STATUS_SRV_END - CODE_W'(1), 8'd2);     idle_gap(1'b0);
		issue(STATUS_SRV_LO - CODE_W'(1), 8'd1);      idle_gap(1'b0);
		issue(STATUS_SRV_END, 8'd1);                  idle_gap(1'b0);
		issue(STATUS_TOO_MANY - CODE_W'(1), 8'd0);    idle_gap(1'b0);
		issue(STATUS_TOO_MANY + CODE_W'(1), 8'd0);    idle_gap(1'b0);
		issue(10'd0, 8'd0);                           idle_gap(1'b0);
		issue(10'd1023, 8'd255);                      idle_gap(1'b0);
		issue(10'd1000, 8'd1);                        idle_gap(1'b0);
		issue(10'd0, 8'd255);                         idle_gap(1'b0);
		issue(STATUS_SRV_END - CODE_W'(1), 8'd255);   idle_gap(1'b0);
		issue(STATUS_SRV_LO, 8'd4);                   idle_gap(1'b0);
		issue(STATUS_TOO_MANY, 8'd23);                idle_gap(1'b0);
		issue(STATUS_TOO_MANY, 8'd24);                idle_gap(1'b0);
		issue(10'd503, 8'd5);                         idle_gap(1'b0);
		issue(10'd1023, 8'd0);                        idle_gap(1'b0);
		issue(10'd0, 8'd1);
		drain();

		// Random phases, each under its own settings; the mix of gaps and
		// back-to-back stretches is drawn anew every sixteen transfers.
		for (int p = 0; p < PHASES; p++) begin
			load_settings(p);
			steady = 1'b0;
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if (i % 16 == 0)
					steady = ($urandom_range(0, 3) == 0);
				issue(pick_status(), pick_count());
				idle_gap(steady);
			end
			drain();
		end

		if (book.mismatches == 0 && book.pending() == 0)
			$display("retry_backoff_policy_tb: clean");
		else
			$display("retry_backoff_policy_tb: errors");
		$finish;
	end

endmodule
